/* rtl/xor_float_stream_encoder_assert.svh */
// Assertion macros for the XOR float stream encoder.
// Included by the top level; the bodies reference i_clk and i_rst_n there.
`ifndef XOR_FLOAT_STREAM_ENCODER_ASSERT_SVH
`define XOR_FLOAT_STREAM_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define XFSE_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("xfse check failed");
`define XFSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("xfse check failed");
`define XFSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("xfse check failed");
`else
`define XFSE_ASSERT(lbl, cond)
`define XFSE_ASSERT_IMP(lbl, ante, cons)
`define XFSE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/xfse_pkg.sv */
// Shared types, constants and bit-count functions of the XOR float stream encoder.
// No dependencies; used by every module of the block.
`default_nettype none
package xfse_pkg;

    localparam int unsigned DATA_W       = 64;
    localparam int unsigned LEN_W        = 7;
    localparam int unsigned LZ_W         = 5;
    localparam int unsigned TZ_W         = 6;
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [LZ_W-1:0]  LZ_MAX        = 5'd31;
    localparam logic [1:0]       CTRL_REUSE    = 2'b01;
    localparam logic [1:0]       CTRL_NEW      = 2'b11;
    localparam logic [LEN_W-1:0] LEN_FULL      = 7'd64;
    localparam logic [LEN_W-1:0] LEN_ZERO      = 7'd1;
    localparam logic [LEN_W-1:0] LEN_CTRL_REUSE = 7'd2;
    localparam logic [LEN_W-1:0] LEN_CTRL_NEW  = 7'd13;
    // largest payload that still fits with its control in one chunk
    localparam logic [LEN_W-1:0] MAX_FIT_REUSE = LEN_FULL - LEN_CTRL_REUSE;
    localparam logic [LEN_W-1:0] MAX_FIT_NEW   = LEN_FULL - LEN_CTRL_NEW;

    // how the back end must encode a request
    typedef enum logic [1:0] {
        KIND_RAW   = 2'd0,
        KIND_ZERO  = 2'd1,
        KIND_REUSE = 2'd2,
        KIND_NEW   = 2'd3
    } t_kind;

    // one classified request between front and back
    typedef struct packed {
        t_kind              kind;
        logic [DATA_W-1:0]  x;      // raw value or XOR with the previous value
        logic [TZ_W-1:0]    tz;     // payload shift
        logic [LZ_W-1:0]    lz;     // clamped leading zeros (new window)
        logic [LEN_W-1:0]   len;    // meaningful bits
    } t_entry;

    // queue occupancy seen by the front end and the top level
    typedef struct packed {
        logic              full;
        logic              not_empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    // leading zeros by halving; valid for a nonzero word
    function automatic logic [TZ_W-1:0] lead_zeros(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] v;
        logic [TZ_W-1:0]   n;
        v = x;
        n = '0;
        if (v[63:32] == '0) begin n[5] = 1'b1; v = v << 32; end
        if (v[63:48] == '0) begin n[4] = 1'b1; v = v << 16; end
        if (v[63:56] == '0) begin n[3] = 1'b1; v = v << 8;  end
        if (v[63:60] == '0) begin n[2] = 1'b1; v = v << 4;  end
        if (v[63:62] == '0) begin n[1] = 1'b1; v = v << 2;  end
        if (v[63] == 1'b0)  begin n[0] = 1'b1; end
        return n;
    endfunction

    // trailing zeros: leading zeros of the bit-reversed word
    function automatic logic [TZ_W-1:0] trail_zeros(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] r;
        for (int i = 0; i < DATA_W; i++) begin
            r[i] = x[DATA_W-1-i];
        end
        return lead_zeros(r);
    endfunction

endpackage
`default_nettype wire

/* rtl/xfse_front.sv */
// Front end: accepts samples, XORs with the previous one, counts zeros,
// decides window reuse and keeps the series state. Uses xfse_pkg.
`default_nettype none
module xfse_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [xfse_pkg::DATA_W-1:0] i_value_bits,
    input  wire logic                       i_series_start,
    input  wire xfse_pkg::t_q_status        i_q_status,
    output logic                            o_stall,
    output logic                            o_push,
    output xfse_pkg::t_entry                o_entry
);

    logic [xfse_pkg::DATA_W-1:0] r_prev, n_prev;
    logic [xfse_pkg::LEN_W-1:0]  r_win_len, n_win_len;
    logic [xfse_pkg::LZ_W-1:0]   r_win_lead, n_win_lead;
    logic [xfse_pkg::TZ_W-1:0]   r_win_trail, n_win_trail;

    logic [xfse_pkg::DATA_W-1:0] w_x;
    logic [xfse_pkg::TZ_W-1:0]   w_lz, w_tz;
    logic [xfse_pkg::LZ_W-1:0]   w_lz_clamp;
    logic [xfse_pkg::LEN_W-1:0]  w_new_len;
    logic                        w_fits;
    logic                        w_accept;

    assign o_stall  = i_q_status.full;
    assign w_accept = i_valid && !i_q_status.full;
    assign o_push   = w_accept;

    // XOR and zero counts
    assign w_x  = i_value_bits ^ r_prev;
    assign w_lz = xfse_pkg::lead_zeros(w_x);
    assign w_tz = xfse_pkg::trail_zeros(w_x);
    assign w_lz_clamp = (w_lz > {1'b0, xfse_pkg::LZ_MAX}) ? xfse_pkg::LZ_MAX
                                                           : w_lz[xfse_pkg::LZ_W-1:0];
    assign w_new_len = xfse_pkg::LEN_FULL - {2'b00, w_lz_clamp} - {1'b0, w_tz};
    assign w_fits = (r_win_len != '0) && ({1'b0, r_win_lead} <= w_lz) && (r_win_trail <= w_tz);

    // classify and compute the next window
    always_comb begin
        n_prev      = r_prev;
        n_win_len   = r_win_len;
        n_win_lead  = r_win_lead;
        n_win_trail = r_win_trail;
        o_entry.x   = w_x;
        o_entry.tz  = w_tz;
        o_entry.lz  = w_lz_clamp;
        o_entry.len = w_new_len;
        if (i_series_start) begin
            o_entry.kind = xfse_pkg::KIND_RAW;
            o_entry.x    = i_value_bits;
            n_win_len    = '0;
            n_win_lead   = '0;
            n_win_trail  = '0;
        end else if (w_x == '0) begin
            o_entry.kind = xfse_pkg::KIND_ZERO;
        end else if (w_fits) begin
            o_entry.kind = xfse_pkg::KIND_REUSE;
            o_entry.tz   = r_win_trail;
            o_entry.len  = r_win_len;
        end else begin
            o_entry.kind = xfse_pkg::KIND_NEW;
            n_win_len    = w_new_len;
            n_win_lead   = w_lz_clamp;
            n_win_trail  = w_tz;
        end
        if (w_accept) begin
            n_prev = i_value_bits;
        end else begin
            n_win_len   = r_win_len;
            n_win_lead  = r_win_lead;
            n_win_trail = r_win_trail;
        end
    end

    // series state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_win_len   <= '0;
            r_win_lead  <= '0;
            r_win_trail <= '0;
        end else begin
            r_prev      <= n_prev;
            r_win_len   <= n_win_len;
            r_win_lead  <= n_win_lead;
            r_win_trail <= n_win_trail;
        end
    end

endmodule
`default_nettype wire

/* rtl/xfse_queue.sv */
// Two-entry request queue between front and back end.
// Uses xfse_pkg for the entry and status types.
`default_nettype none
module xfse_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire xfse_pkg::t_entry    i_entry,
    input  wire logic                i_pop,
    output xfse_pkg::t_entry         o_head,
    output xfse_pkg::t_q_status      o_status
);

    xfse_pkg::t_entry              r_mem [xfse_pkg::QUEUE_DEPTH];
    logic [xfse_pkg::QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [xfse_pkg::QCNT_W-1:0]   r_count, n_count;
    logic                          w_push, w_pop;

    assign w_push = i_push && (r_count != xfse_pkg::QCNT_W'(xfse_pkg::QUEUE_DEPTH));
    assign w_pop  = i_pop && (r_count != '0);

    assign o_head             = r_mem[r_rd_ptr];
    assign o_status.full      = (r_count == xfse_pkg::QCNT_W'(xfse_pkg::QUEUE_DEPTH));
    assign o_status.not_empty = (r_count != '0);
    assign o_status.count     = r_count;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/xfse_back.sv */
// Back end: turns queued requests into one or two chunks and holds the
// output register. Uses xfse_pkg.
`default_nettype none
module xfse_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire xfse_pkg::t_entry            i_head,
    input  wire logic                        i_head_valid,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [xfse_pkg::DATA_W-1:0]      o_chunk_bits,
    output logic [xfse_pkg::LEN_W-1:0]       o_chunk_len,
    output logic                             o_last_chunk
);

    logic                         r_valid;
    logic                         r_phase, n_phase;
    logic [xfse_pkg::DATA_W-1:0]  r_bits, n_bits;
    logic [xfse_pkg::LEN_W-1:0]   r_len, n_len;
    logic                         r_last, n_last;

    logic [xfse_pkg::DATA_W-1:0]  w_payload;
    logic [xfse_pkg::DATA_W-1:0]  w_ctrl;
    logic                         w_two;
    logic                         w_load;

    assign o_valid      = r_valid;
    assign o_chunk_bits = r_bits;
    assign o_chunk_len  = r_len;
    assign o_last_chunk = r_last;

    assign w_payload = i_head.x >> i_head.tz;
    assign w_ctrl    = {51'd0, i_head.len[5:0], i_head.lz, xfse_pkg::CTRL_NEW};
    assign w_two = ((i_head.kind == xfse_pkg::KIND_REUSE) &&
                    (i_head.len > xfse_pkg::MAX_FIT_REUSE)) ||
                   ((i_head.kind == xfse_pkg::KIND_NEW) &&
                    (i_head.len > xfse_pkg::MAX_FIT_NEW));
    assign w_load = i_head_valid && (!r_valid || !i_stall);
    assign o_pop  = w_load && (r_phase || !w_two);

    // chunk formation
    always_comb begin
        n_phase = r_phase;
        n_bits  = w_payload;
        n_len   = i_head.len;
        n_last  = 1'b1;
        if (r_phase) begin
            n_phase = 1'b0;
        end else begin
            unique case (i_head.kind)
                xfse_pkg::KIND_RAW: begin
                    n_bits = i_head.x;
                    n_len  = xfse_pkg::LEN_FULL;
                end
                xfse_pkg::KIND_ZERO: begin
                    n_bits = '0;
                    n_len  = xfse_pkg::LEN_ZERO;
                end
                xfse_pkg::KIND_REUSE: begin
                    if (w_two) begin
                        n_bits  = {62'd0, xfse_pkg::CTRL_REUSE};
                        n_len   = xfse_pkg::LEN_CTRL_REUSE;
                        n_last  = 1'b0;
                        n_phase = 1'b1;
                    end else begin
                        n_bits = {62'd0, xfse_pkg::CTRL_REUSE} | (w_payload << 2);
                        n_len  = i_head.len + xfse_pkg::LEN_CTRL_REUSE;
                    end
                end
                xfse_pkg::KIND_NEW: begin
                    if (w_two) begin
                        n_bits  = w_ctrl;
                        n_len   = xfse_pkg::LEN_CTRL_NEW;
                        n_last  = 1'b0;
                        n_phase = 1'b1;
                    end else begin
                        n_bits = w_ctrl | (w_payload << 13);
                        n_len  = i_head.len + xfse_pkg::LEN_CTRL_NEW;
                    end
                end
                default: begin
                    n_bits = '0;
                end
            endcase
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bits <= n_bits;
            r_len  <= n_len;
            r_last <= n_last;
        end
    end

    // output valid and split phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_phase <= n_phase;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/xor_float_stream_encoder.sv */
// XOR float stream encoder: takes one 64-bit sample per cycle unless stalled and emits
// bit chunks (value, length, last) for an LSB-first stream. A sample that
// opens a series goes out raw; a repeat goes out as one 0 bit; other
// samples are XORed with the previous one and coded against the current
// window (control 01) or open a new one (control 11, 5-bit leading zeros,
// 6-bit length). The front end takes one request per cycle while the queue is not full
// and finishes the window state in that cycle; a two-entry queue feeds the back end,
// which emits one chunk per cycle while the output is not stalled. Throughput is one
// request per cycle when nothing stalls, except a request whose chunk exceeds 64 bits,
// which goes out as two chunks. A request is queued, then loaded into the output register.
`default_nettype none
`include "xor_float_stream_encoder_assert.svh"
module xor_float_stream_encoder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [xfse_pkg::DATA_W-1:0] i_value_bits,
    input  wire logic                        i_series_start,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [xfse_pkg::DATA_W-1:0]      o_chunk_bits,
    output logic [xfse_pkg::LEN_W-1:0]       o_chunk_len,
    output logic                             o_last_chunk
);

    xfse_pkg::t_q_status w_q_status;
    xfse_pkg::t_entry    w_push_entry;
    xfse_pkg::t_entry    w_head;
    logic                w_push;
    logic                w_pop;

    // classification and window state
    xfse_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_value_bits   (i_value_bits),
        .i_series_start (i_series_start),
        .i_q_status     (w_q_status),
        .o_stall        (o_stall),
        .o_push         (w_push),
        .o_entry        (w_push_entry)
    );

    // decoupling queue
    xfse_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // chunk formation and output register
    xfse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (w_q_status.not_empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_chunk_bits (o_chunk_bits),
        .o_chunk_len  (o_chunk_len),
        .o_last_chunk (o_last_chunk)
    );

    // queue never overfills
    `XFSE_ASSERT(a_queue_bound, w_q_status.count <= 2'd2)
    // a split request's first chunk is a bare control word
    `XFSE_ASSERT_IMP(a_split_ctrl, o_valid && !o_last_chunk, o_chunk_len == 7'd2 || o_chunk_len == 7'd13)
    // the second chunk of a split request follows right after the first
    `XFSE_ASSERT_NEXT(a_split_follow, o_valid && !i_stall && !o_last_chunk, o_valid)
    // no chunk is empty or longer than a word
    `XFSE_ASSERT_IMP(a_len_range, o_valid, o_chunk_len != 7'd0 && o_chunk_len <= 7'd64)

endmodule
`default_nettype wire

/* test/xor_float_stream_encoder_test.sv */
// Testbench for xor_float_stream_encoder: drives samples, predicts the chunk stream
// in place and checks every chunk field by field. Depends on xfse_pkg and the RTL only.
`default_nettype none
module xor_float_stream_encoder_test;

    localparam int unsigned IDLE_LIMIT = 1000;
    localparam int unsigned TAIL_WAIT  = 10;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic [xfse_pkg::DATA_W-1:0]         i_value_bits;
    logic                                i_series_start;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic [xfse_pkg::DATA_W-1:0]         o_chunk_bits;
    logic [xfse_pkg::LEN_W-1:0]          o_chunk_len;
    logic                                o_last_chunk;

    // one expected output chunk
    typedef struct {
        logic [xfse_pkg::DATA_W-1:0] bits;
        logic [xfse_pkg::LEN_W-1:0]  len;
        logic                        last;
    } t_chunk;

    t_chunk            chunk_q[$];
    t_chunk            want;
    int unsigned       errors = 0;
    int unsigned       idle_cycles = 0;
    logic              gap_on;
    logic              stall_on;

    // encoder state as the predictor sees it
    logic [xfse_pkg::DATA_W-1:0] prev_sample;
    logic [xfse_pkg::LEN_W-1:0]  win_len;
    logic [xfse_pkg::LZ_W-1:0]   win_lead;
    logic [xfse_pkg::TZ_W-1:0]   win_trail;

    xor_float_stream_encoder uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value_bits   (i_value_bits),
        .i_series_start (i_series_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_chunk_bits   (o_chunk_bits),
        .o_chunk_len    (o_chunk_len),
        .o_last_chunk   (o_last_chunk)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [xfse_pkg::DATA_W-1:0] mask_low(input int unsigned n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic logic [xfse_pkg::DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void push_chunk(input logic [xfse_pkg::DATA_W-1:0] bits,
                                       input int unsigned len, input logic last);
        t_chunk c;
        c.bits = bits & mask_low(len);
        c.len  = xfse_pkg::LEN_W'(len);
        c.last = last;
        chunk_q.push_back(c);
    endfunction

    // expected chunks for one accepted request; updates the window state
    function automatic void predict_chunks(input logic [xfse_pkg::DATA_W-1:0] v,
                                           input logic s);
        logic [xfse_pkg::DATA_W-1:0] x;
        logic [xfse_pkg::DATA_W-1:0] payload;
        logic [xfse_pkg::DATA_W-1:0] ctrl;
        int unsigned                 lz;
        int unsigned                 tz;
        int unsigned                 n;
        if (s) begin
            prev_sample = v;
            win_len     = '0;
            win_lead    = '0;
            win_trail   = '0;
            push_chunk(v, 64, 1'b1);
            return;
        end
        x = v ^ prev_sample;
        prev_sample = v;
        if (x == '0) begin
            push_chunk('0, xfse_pkg::LEN_ZERO, 1'b1);
            return;
        end
        lz = 0;
        while (lz < 64 && !x[63-lz]) lz++;
        tz = 0;
        while (tz < 64 && !x[tz]) tz++;
        // reuse the current window when the meaningful bits fit inside it
        if (win_len != 0 && win_lead <= lz && win_trail <= tz) begin
            payload = x >> win_trail;
            n = win_len;
            if (n + xfse_pkg::LEN_CTRL_REUSE <= 64) begin
                push_chunk(64'(xfse_pkg::CTRL_REUSE) | (payload << 2),
                           n + xfse_pkg::LEN_CTRL_REUSE, 1'b1);
            end else begin
                push_chunk(64'(xfse_pkg::CTRL_REUSE), xfse_pkg::LEN_CTRL_REUSE, 1'b0);
                push_chunk(payload, n, 1'b1);
            end
            return;
        end
        // open a new window
        if (lz > 31) lz = 31;
        n = 64 - lz - tz;
        payload = x >> tz;
        ctrl = 64'(xfse_pkg::CTRL_NEW) | (64'(lz) << 2) | (64'((n == 64) ? 0 : n) << 7);
        win_len   = xfse_pkg::LEN_W'(n);
        win_lead  = xfse_pkg::LZ_W'(lz);
        win_trail = xfse_pkg::TZ_W'(tz);
        if (n + xfse_pkg::LEN_CTRL_NEW <= 64) begin
            push_chunk(ctrl | (payload << 13), n + xfse_pkg::LEN_CTRL_NEW, 1'b1);
        end else begin
            push_chunk(ctrl, xfse_pkg::LEN_CTRL_NEW, 1'b0);
            push_chunk(payload, n, 1'b1);
        end
    endfunction

    // one request: random idle gap, hold until taken, then predict
    task automatic send_sample(input logic [xfse_pkg::DATA_W-1:0] v, input logic s);
        while (gap_on && $urandom_range(99) < 26) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_value_bits   <= v;
        i_series_start <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_chunks(v, s);
        @(negedge i_clk);
    endtask

    // sample whose XOR with the previous one is x
    task automatic send_xor(input logic [xfse_pkg::DATA_W-1:0] x);
        send_sample(prev_sample ^ x, 1'b0);
    endtask

    // hold requests off until every expected chunk has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (chunk_q.size() != 0);
    endtask

    // XOR confined to the current window
    function automatic logic [xfse_pkg::DATA_W-1:0] window_xor();
        logic [xfse_pkg::DATA_W-1:0] x;
        x = rand64() & (mask_low(win_len) << win_trail);
        if ($urandom_range(3) == 0) begin
            x[win_trail] = 1'b1;
            x[win_trail + win_len - 1] = 1'b1;
        end
        if (x == '0) x[win_trail] = 1'b1;
        return x;
    endfunction

    // XOR with a chosen span of meaningful bits
    function automatic logic [xfse_pkg::DATA_W-1:0] span_xor();
        logic [xfse_pkg::DATA_W-1:0] x;
        int unsigned                 lz;
        int unsigned                 tz;
        lz = ($urandom_range(4) == 0) ? 0 : $urandom_range(63);
        tz = ($urandom_range(4) == 0) ? 0 : $urandom_range(63 - lz);
        x = rand64() & (mask_low(64 - lz - tz) << tz);
        x[63-lz] = 1'b1;
        x[tz]    = 1'b1;
        return x;
    endfunction

    // extremes, window boundaries and split cases
    task automatic test_directed();
        send_sample(64'h3FF0_0000_0000_0000, 1'b0);   // no series yet: XOR with zero
        send_xor('0);                                 // repeat
        send_sample('1, 1'b1);
        send_sample('0, 1'b1);
        send_xor('1);                                 // full width, length coded as 0
        send_xor(64'h8000_0000_0000_0001);            // reuse full window, split
        send_xor(64'h0000_0000_0000_0001);
        send_sample('0, 1'b1);
        send_xor(64'h0000_0000_0000_0001);            // leading zeros clamped
        send_xor(64'h0000_0000_0000_0002);            // reuse, fits
        send_xor(64'h8000_0000_0000_0000);            // one bit at the top
        send_xor((64'd1 << 50) | 64'd1);              // new window, exactly 64 bits
        send_xor((64'd1 << 51) | 64'd1);              // new window, split
        send_xor((64'd1 << 62) | 64'd2);
        send_xor((64'd1 << 61) | 64'd4);              // reuse, exactly 64 bits
        send_xor((64'd1 << 63) | 64'd2);
        send_xor((64'd1 << 62) | 64'd2);              // reuse, split
        send_xor('0);
        send_sample(64'h7FF8_0000_0000_0000, 1'b1);
        send_xor(64'hFFFF_FFFF_0000_0000);
        send_xor(64'h0000_0000_FFFF_FFFF);
    endtask

    // mostly well-formed XOR patterns, plus raw noise and series restarts
    task automatic test_random(input int unsigned count);
        int unsigned pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 7)
                send_sample(rand64(), 1'b1);
            else if (pick < 12)
                send_sample(rand64(), 1'b0);
            else if (pick < 25)
                send_xor('0);
            else if (pick < 62 && win_len != 0)
                send_xor(window_xor());
            else
                send_xor(span_xor());
        end
    endtask

    // sender stops until the output side has caught up
    task automatic test_drain_pause();
        test_random(10);
        wait_drained();
        test_random(10);
        wait_drained();
    endtask

    // back-to-back requests with the output never stalled
    task automatic test_no_idle(input int unsigned count);
        gap_on   = 1'b0;
        stall_on = 1'b0;
        test_random(count);
        gap_on   = 1'b1;
        stall_on = 1'b1;
    endtask

    // output side stalls at random
    always @(negedge i_clk) begin
        i_stall <= stall_on && ($urandom_range(99) < 26);
    end

    // compare each chunk with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (chunk_q.size() == 0) begin
                $error("unexpected chunk: bits %h len %0d", o_chunk_bits, o_chunk_len);
                errors++;
            end else begin
                want = chunk_q.pop_front();
                if (o_chunk_bits !== want.bits) begin
                    $error("chunk_bits: expected %h, got %h", want.bits, o_chunk_bits);
                    errors++;
                end
                if (o_chunk_len !== want.len) begin
                    $error("chunk_len: expected %0d, got %0d", want.len, o_chunk_len);
                    errors++;
                end
                if (o_last_chunk !== want.last) begin
                    $error("last_chunk: expected %b, got %b", want.last, o_last_chunk);
                    errors++;
                end
            end
        end
    end

    // watchdog: no request taken and no chunk out for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_value_bits   = '0;
        i_series_start = 1'b0;
        gap_on         = 1'b1;
        stall_on       = 1'b1;
        prev_sample    = '0;
        win_len        = '0;
        win_lead       = '0;
        win_trail      = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_no_idle(80);
        test_drain_pause();
        test_random(380);

        wait_drained();
        repeat (TAIL_WAIT) @(negedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/xfse_pkg.sv
rtl/xfse_front.sv
rtl/xfse_queue.sv
rtl/xfse_back.sv
rtl/xor_float_stream_encoder.sv
test/xor_float_stream_encoder_test.sv
